// ===== rtl/core/lds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lds_pkg;

  // Default sizes
  localparam int DEF_LIST_DEPTH = 64;
  localparam int DEF_TRACK_BITS = 16;
  localparam int DEF_TAG_BITS   = 8;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // List selectors
  localparam logic LIST_SWEEP  = 1'b0;
  localparam logic LIST_RETURN = 1'b1;

  // Classification of one queued item
  typedef struct packed {
    logic is_get;
    logic to_sweep;
  } job_ctrl_t;

  // Queue status seen by a producer or a consumer
  typedef struct packed {
    logic full;
    logic avail;
  } queue_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/lds_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lds_fifo #(
  parameter int WIDTH = 34
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire [WIDTH-1:0]        push_data,
  input  wire                    pop,
  output logic [WIDTH-1:0]       pop_data,
  output lds_pkg::queue_stat_t   stat
);
  import lds_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    fill_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    q = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      fill_r <= fill_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = slot_r[rd_ptr_r];
  assign stat.full  = (fill_r == CW'(QUEUE_DEPTH));
  assign stat.avail = (fill_r != '0);

endmodule
`default_nettype wire

// ===== rtl/core/lds_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lds_front #(
  parameter int TRACK_BITS = 16,
  parameter int TAG_BITS   = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_command,
  input  wire [TAG_BITS-1:0]           in_request_tag,
  input  wire [TRACK_BITS-1:0]         in_request_track,
  input  wire [TRACK_BITS-1:0]         in_head_track,
  input  wire lds_pkg::queue_stat_t    q_stat,
  output logic                         q_push,
  output logic [TAG_BITS+TRACK_BITS+1:0] q_data
);
  import lds_pkg::*;

  logic                  hold_v_r;
  job_ctrl_t             ctrl_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [TRACK_BITS-1:0] trk_r;
  logic                  take;

  // Holding stage: moves on as soon as the queue has room
  assign busy   = hold_v_r & q_stat.full;
  assign take   = start & ~busy;
  assign q_push = hold_v_r & ~q_stat.full;
  assign q_data = {ctrl_r, tag_r, trk_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (take) begin
      hold_v_r <= 1'b1;
    end else if (q_push) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctrl_r.is_get   <= (in_command == CMD_GET);
      ctrl_r.to_sweep <= (in_head_track <= in_request_track);
      tag_r           <= in_request_tag;
      trk_r           <= in_request_track;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lds_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lds_back #(
  parameter int LIST_DEPTH = 64,
  parameter int TRACK_BITS = 16,
  parameter int TAG_BITS   = 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire lds_pkg::queue_stat_t      q_stat,
  input  wire [TAG_BITS+TRACK_BITS+1:0]  q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  output logic                           out_granted,
  output logic [TAG_BITS-1:0]            out_granted_tag,
  output logic [TRACK_BITS-1:0]          out_granted_track,
  output logic                           out_error,
  output logic                           out_queue_empty
);
  import lds_pkg::*;

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int EW = TAG_BITS + TRACK_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUT, S_POP} state_t;

  // Entries {track, tag}; each list is a ring from its base
  logic [EW-1:0] mem_sw [LIST_DEPTH];
  logic [EW-1:0] mem_rt [LIST_DEPTH];
  logic [EW-1:0] rd_sw_r, rd_rt_r, rd_entry;

  state_t                state_r, state_nxt;
  logic                  lst_r, lst_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [TRACK_BITS-1:0] trk_r, trk_nxt;
  logic [IW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         cnt_r [2];
  logic [CW-1:0]         cnt_nxt [2];
  logic [IW-1:0]         base_r [2];
  logic [IW-1:0]         base_nxt [2];

  logic                  valid_r, valid_nxt;
  logic                  gnt_r, gnt_nxt;
  logic [TAG_BITS-1:0]   gtag_r, gtag_nxt;
  logic [TRACK_BITS-1:0] gtrk_r, gtrk_nxt;
  logic                  err_r, err_nxt;
  logic                  empty_r, empty_nxt;

  logic                  we, wlist, lsel, after;
  logic [IW-1:0]         waddr, raddr;
  logic [EW-1:0]         wdata;
  logic [CW-1:0]         cnt_m1;
  job_ctrl_t             q_ctrl;
  logic [TAG_BITS-1:0]   q_tag;
  logic [TRACK_BITS-1:0] q_trk;
  logic [TRACK_BITS-1:0] rd_trk;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(LIST_DEPTH)) begin
      sum = sum - (IW+1)'(LIST_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign {q_ctrl, q_tag, q_trk} = q_data;
  assign rd_entry = (lst_r == LIST_RETURN) ? rd_rt_r : rd_sw_r;
  assign rd_trk   = rd_entry[EW-1:TAG_BITS];
  assign after    = (lst_r == LIST_SWEEP) ? (rd_trk > trk_r) : (rd_trk < trk_r);

  always_comb begin
    state_nxt   = state_r;
    lst_nxt     = lst_r;
    tag_nxt     = tag_r;
    trk_nxt     = trk_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    base_nxt    = base_r;
    valid_nxt   = 1'b0;
    gnt_nxt     = 1'b0;
    gtag_nxt    = '0;
    gtrk_nxt    = '0;
    err_nxt     = 1'b0;
    q_pop       = 1'b0;
    we          = 1'b0;
    wlist       = lst_r;
    lsel        = LIST_SWEEP;
    waddr       = phys(base_r[lst_r], pos_r + IW'(1));
    wdata       = {trk_r, tag_r};
    raddr       = phys(base_r[lst_r], pos_r);
    cnt_m1      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_stat.avail) begin
          q_pop   = 1'b1;
          tag_nxt = q_tag;
          trk_nxt = q_trk;
          if (!q_ctrl.is_get) begin
            lsel    = q_ctrl.to_sweep ? LIST_SWEEP : LIST_RETURN;
            lst_nxt = lsel;
            wlist   = lsel;
            cnt_m1  = cnt_r[lsel] - CW'(1);
            if (cnt_r[lsel] == CW'(LIST_DEPTH)) begin
              valid_nxt = 1'b1;
              err_nxt   = 1'b1;
            end else if (cnt_r[lsel] == '0) begin
              we            = 1'b1;
              waddr         = base_r[lsel];
              wdata         = {q_trk, q_tag};
              cnt_nxt[lsel] = CW'(1);
              valid_nxt     = 1'b1;
            end else begin
              // scan from the tail towards the front
              pos_nxt   = cnt_m1[IW-1:0];
              raddr     = phys(base_r[lsel], cnt_m1[IW-1:0]);
              state_nxt = S_SCAN;
            end
          end else begin
            if (cnt_r[LIST_SWEEP] != '0) begin
              lst_nxt   = LIST_SWEEP;
              raddr     = base_r[LIST_SWEEP];
              state_nxt = S_POP;
            end else if (cnt_r[LIST_RETURN] != '0) begin
              lst_nxt   = LIST_RETURN;
              raddr     = base_r[LIST_RETURN];
              state_nxt = S_POP;
            end else begin
              valid_nxt = 1'b1;
              err_nxt   = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        we = 1'b1;
        if (after) begin
          // entry moves one place back
          wdata = rd_entry;
          if (pos_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            raddr   = phys(base_r[lst_r], pos_r - IW'(1));
            pos_nxt = pos_r - IW'(1);
          end
        end else begin
          cnt_nxt[lst_r] = cnt_r[lst_r] + CW'(1);
          valid_nxt      = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_PUT: begin
        we             = 1'b1;
        waddr          = phys(base_r[lst_r], pos_r);
        cnt_nxt[lst_r] = cnt_r[lst_r] + CW'(1);
        valid_nxt      = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_POP: begin
        base_nxt[lst_r] = phys(base_r[lst_r], IW'(1));
        cnt_nxt[lst_r]  = cnt_r[lst_r] - CW'(1);
        valid_nxt       = 1'b1;
        gnt_nxt         = 1'b1;
        gtag_nxt        = rd_entry[TAG_BITS-1:0];
        gtrk_nxt        = rd_trk;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    empty_nxt = (cnt_nxt[LIST_SWEEP] == '0) && (cnt_nxt[LIST_RETURN] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= S_IDLE;
      cnt_r[LIST_SWEEP]   <= '0;
      cnt_r[LIST_RETURN]  <= '0;
      base_r[LIST_SWEEP]  <= '0;
      base_r[LIST_RETURN] <= '0;
      valid_r             <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      base_r   <= base_nxt;
      valid_r  <= valid_nxt;
    end
    lst_r   <= lst_nxt;
    tag_r   <= tag_nxt;
    trk_r   <= trk_nxt;
    pos_r   <= pos_nxt;
    gnt_r   <= gnt_nxt;
    gtag_r  <= gtag_nxt;
    gtrk_r  <= gtrk_nxt;
    err_r   <= err_nxt;
    empty_r <= empty_nxt;
  end

  // List storage: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we && (wlist == LIST_SWEEP)) begin
      mem_sw[waddr] <= wdata;
    end
    if (we && (wlist == LIST_RETURN)) begin
      mem_rt[waddr] <= wdata;
    end
    rd_sw_r <= mem_sw[raddr];
    rd_rt_r <= mem_rt[raddr];
  end

  assign out_valid         = valid_r;
  assign out_granted       = gnt_r;
  assign out_granted_tag   = gtag_r;
  assign out_granted_track = gtrk_r;
  assign out_error         = err_r;
  assign out_queue_empty   = empty_r;

endmodule
`default_nettype wire

// ===== rtl/core/look_disk_request_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// LOOK disk-arm request scheduler.
// Input: an item is taken on a clock edge with start high and busy low.
//   in_command 0 files a request (in_request_tag, in_request_track) against
//   in_head_track: at or above the head it joins the ascending sweep list,
//   below it the descending return list; equal tracks keep arrival order.
//   in_command 1 pops the sweep front, else the return front.
// Output: one result per item, in order, shown for a single cycle with
//   out_valid high. The receiver cannot stall; results are never held.
// The front stage registers an item and pushes it into the queue; the back
//   end pops it when idle. A get grants a list front in its pop state, or an
//   error if both lists are empty; an add to an empty or full (error) list
//   resolves while idle; any other add scans from the tail, moving each later
//   entry one place back, then writes the new one in the gap. The ordered
//   insert, one stored entry per cycle through the list memory port, sets the rate.
// A front stage and a two-item queue let new items be taken while the back
//   end is still scanning; busy rises only when the queue is full and the
//   front stage still holds an item.
// Reset (rst_n low, synchronous) empties both lists; no clearing pass is
//   needed since entries are only read below their fill count.
module look_disk_request_scheduler_unit #(
  parameter int LIST_DEPTH = lds_pkg::DEF_LIST_DEPTH,
  parameter int TRACK_BITS = lds_pkg::DEF_TRACK_BITS,
  parameter int TAG_BITS   = lds_pkg::DEF_TAG_BITS
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire                   in_command,
  input  wire [TAG_BITS-1:0]    in_request_tag,
  input  wire [TRACK_BITS-1:0]  in_request_track,
  input  wire [TRACK_BITS-1:0]  in_head_track,
  output logic                  out_valid,
  output logic                  out_granted,
  output logic [TAG_BITS-1:0]   out_granted_tag,
  output logic [TRACK_BITS-1:0] out_granted_track,
  output logic                  out_error,
  output logic                  out_queue_empty
);
  import lds_pkg::*;

  localparam int QW = TAG_BITS + TRACK_BITS + 2;

  queue_stat_t   q_stat;
  logic          q_push, q_pop;
  logic [QW-1:0] q_in, q_out;

  // Front: takes and classifies items
  lds_front #(
    .TRACK_BITS (TRACK_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_request_tag   (in_request_tag),
    .in_request_track (in_request_track),
    .in_head_track    (in_head_track),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  // Short decoupling queue
  lds_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // Back: list storage, ordered insert and pop
  lds_back #(
    .LIST_DEPTH (LIST_DEPTH),
    .TRACK_BITS (TRACK_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_data            (q_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_granted       (out_granted),
    .out_granted_tag   (out_granted_tag),
    .out_granted_track (out_granted_track),
    .out_error         (out_error),
    .out_queue_empty   (out_queue_empty)
  );

endmodule
`default_nettype wire
